[rtl/signature_byte_scanner_defines.svh]
`ifndef SIGNATURE_BYTE_SCANNER_DEFINES_SVH
`define SIGNATURE_BYTE_SCANNER_DEFINES_SVH

// same-cycle implication, checked on clk and disabled during reset
`define SBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("signature_byte_scanner check failed");

// next-cycle implication, checked on clk and disabled during reset
`define SBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("signature_byte_scanner check failed");

`endif

[rtl/sbs_pkg.sv]
`timescale 1ns / 1ps

package sbs_pkg;

	localparam int MAX_SIGNATURES_DEF = 16;
	localparam int MAX_SIG_LEN_DEF    = 32;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_SCAN  = 2'd2;

	localparam logic [1:0] STATUS_CLEAN    = 2'd0;
	localparam logic [1:0] STATUS_INFECTED = 2'd1;
	localparam logic [1:0] STATUS_ERROR    = 2'd2;

	// command broadcast to every cell, qualified by the input transfer
	typedef struct packed {
		logic       load;
		logic       clear;
		logic       scan;
		logic       last;
		logic [3:0] slot;
		logic [4:0] position;
		logic [7:0] byte_value;
	} cmd_t;

	// result carry passed from cell to cell
	typedef struct packed {
		logic       any;
		logic       hit;
		logic [3:0] slot;
	} chain_t;

endpackage

[rtl/signature_byte_scanner.sv]
`timescale 1ns / 1ps

// channel | handshake                  | payload
// item    | item_valid / item_stall     | kind, slot, position, byte_value, last
// result  | result_valid / result_stall | status, match_slot
//
// one item per cycle while item_stall is low; a final scan byte gives its result on the next cycle
// every slot is a cell that compares the byte against all its signature bytes at once
// the result is resolved through the carry running from cell 0 upwards
// reset clears valid, match and seen state; signature bytes hold until loaded
// item_stall rises only for a final scan byte while a stalled result still waits

module signature_byte_scanner #(
	parameter int MAX_SIGNATURES = sbs_pkg::MAX_SIGNATURES_DEF,
	parameter int MAX_SIG_LEN    = sbs_pkg::MAX_SIG_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] kind,
	input  logic [3:0] slot,
	input  logic [4:0] position,
	input  logic [7:0] byte_value,
	input  logic       last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] status,
	output logic [3:0] match_slot
);

	logic            accept;
	sbs_pkg::cmd_t   cmd;
	sbs_pkg::chain_t chain [MAX_SIGNATURES + 1];
	sbs_pkg::chain_t fin;

	logic       result_valid_q;
	logic [1:0] status_q;
	logic [3:0] match_slot_q;

	assign item_stall = result_valid_q && result_stall
		&& (kind == sbs_pkg::KIND_SCAN) && last;
	assign accept = item_valid && !item_stall;

	assign cmd.load       = accept && (kind == sbs_pkg::KIND_LOAD);
	assign cmd.clear      = accept && (kind == sbs_pkg::KIND_CLEAR);
	assign cmd.scan       = accept && (kind == sbs_pkg::KIND_SCAN);
	assign cmd.last       = last;
	assign cmd.slot       = slot;
	assign cmd.position   = position;
	assign cmd.byte_value = byte_value;

	assign chain[0] = '0;

	for (genvar k = 0; k < MAX_SIGNATURES; k++) begin : g_cell
		sbs_cell #(
			.SIG_LEN(MAX_SIG_LEN),
			.INDEX  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.chain_in (chain[k]),
			.chain_out(chain[k + 1])
		);
	end

	assign fin = chain[MAX_SIGNATURES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.scan && last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && last) begin
			priority if (!fin.any) begin
				status_q     <= sbs_pkg::STATUS_ERROR;
				match_slot_q <= '0;
			end else if (fin.hit) begin
				status_q     <= sbs_pkg::STATUS_INFECTED;
				match_slot_q <= fin.slot;
			end else begin
				status_q     <= sbs_pkg::STATUS_CLEAN;
				match_slot_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign match_slot   = match_slot_q;

endmodule

[rtl/sbs_cell.sv]
`timescale 1ns / 1ps

module sbs_cell #(
	parameter int SIG_LEN = sbs_pkg::MAX_SIG_LEN_DEF,
	parameter int INDEX   = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sbs_pkg::cmd_t   cmd,
	input  sbs_pkg::chain_t chain_in,
	output sbs_pkg::chain_t chain_out
);

	localparam int LW = (SIG_LEN > 1) ? $clog2(SIG_LEN) : 1;

	logic [7:0]         pat_q [SIG_LEN];
	logic [LW-1:0]      last_idx_q;
	logic               valid_q;
	logic [SIG_LEN-1:0] part_q;
	logic               seen_q;

	logic [LW-1:0]      pos_idx;
	logic               sel;
	logic [SIG_LEN-1:0] part_adv;
	logic               found;
	logic               seen_next;

	assign pos_idx = LW'(cmd.position);
	assign sel = cmd.load && (int'(cmd.slot) == INDEX) && (int'(cmd.position) < SIG_LEN);

	always_comb begin
		for (int i = 0; i < SIG_LEN; i++) begin
			if (i <= int'(last_idx_q)) begin
				part_adv[i] = ((i == 0) ? 1'b1 : part_q[(i == 0) ? 0 : i - 1])
					&& (pat_q[i] == cmd.byte_value);
			end else begin
				part_adv[i] = part_q[i];
			end
		end
	end

	assign found     = part_adv[last_idx_q];
	assign seen_next = seen_q | (cmd.scan & valid_q & found);

	always_comb begin
		chain_out.any  = chain_in.any | valid_q;
		chain_out.hit  = chain_in.hit;
		chain_out.slot = chain_in.slot;
		if (!chain_in.hit && valid_q && seen_next) begin
			chain_out.hit  = 1'b1;
			chain_out.slot = 4'(INDEX);
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			pat_q[pos_idx] <= cmd.byte_value;
			if (cmd.last) begin
				last_idx_q <= pos_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			part_q  <= '0;
			seen_q  <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
			part_q  <= '0;
			seen_q  <= 1'b0;
		end else if (sel) begin
			part_q <= '0;
			seen_q <= 1'b0;
			if (cmd.last) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.scan) begin
			if (cmd.last) begin
				part_q <= '0;
				seen_q <= 1'b0;
			end else if (valid_q) begin
				part_q <= part_adv;
				seen_q <= seen_next;
			end
		end
	end

endmodule

[rtl/sbs_checker.sv]
`timescale 1ns / 1ps
`include "signature_byte_scanner_defines.svh"

module sbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] kind,
	input logic       last,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] status,
	input logic [3:0] match_slot
);

	logic acc;

	assign acc = item_valid && !item_stall;

	`SBS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(match_slot))
	`SBS_ASSERT_NOW(a_slot_zero, result_valid && (status != sbs_pkg::STATUS_INFECTED), match_slot == 4'd0)
	`SBS_ASSERT_NEXT(a_final_gives_result, acc && (kind == sbs_pkg::KIND_SCAN) && last, result_valid)
	`SBS_ASSERT_NEXT(a_error_after_clear, (acc && (kind == sbs_pkg::KIND_CLEAR)) ##1 (acc && (kind == sbs_pkg::KIND_SCAN) && last), status == sbs_pkg::STATUS_ERROR)

endmodule

bind signature_byte_scanner sbs_checker u_sbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.kind        (kind),
	.last        (last),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.status      (status),
	.match_slot  (match_slot)
);
